// File: src/ltkc_pkg.sv
// Shared constants and types for the lamp touch/key controller.
package ltkc_pkg;

  // Stream word widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_ZERO          = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_ONE           = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_TWO           = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THREE         = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS       = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_OFF_TICKS      = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_POWER_OFF_TICKS = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_GRACE_TICKS     = 4'd7;

  // Register reset values
  localparam logic [7:0]  LEVEL_ZERO_RST          = 8'd0;
  localparam logic [7:0]  LEVEL_ONE_RST           = 8'd64;
  localparam logic [7:0]  LEVEL_TWO_RST           = 8'd128;
  localparam logic [7:0]  LEVEL_THREE_RST         = 8'd255;
  localparam logic [15:0] LONG_PRESS_MS_RST       = 16'd1000;
  localparam logic [15:0] IDLE_OFF_TICKS_RST      = 16'd60000;
  localparam logic [15:0] LOW_POWER_OFF_TICKS_RST = 16'd30000;
  localparam logic [15:0] OFF_GRACE_TICKS_RST     = 16'd1000;

  // Fixed behavior constants
  localparam logic [7:0]  RAMP_TOP        = 8'd255;
  localparam logic [7:0]  RAMP_FLOOR      = 8'd20;
  localparam logic [7:0]  LOW_POWER_LEVEL = 8'd12;
  localparam logic [4:0]  TOUCH_PHASES    = 5'd15;
  localparam logic [4:0]  KEY_PHASES      = 5'd10;
  localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;

  // Result word, lowest bit first: write, luminance, colour, dot, off, shutdown
  typedef struct packed {
    logic [2:0] pad;
    logic       shutdown;
    logic       off_pending;
    logic       dot_mode_toggle;
    logic       colour_step;
    logic [7:0] luminance;
    logic       luminance_write;
  } result_t;

endpackage

// File: src/lamp_touch_key_controller_top.sv
// Top level of the lamp touch/key controller: per-tick state update and result register.
//
// Each accepted poll word produces exactly one result word in the next cycle. The block
// accepts a new poll word in every cycle: the whole tick update (two 32-bit elapsed-time
// compares, the level step, and the idle counter add and compare) settles between the
// input port and the single result register, and s_axis_tready stays high while that
// register is empty or being taken. Throughput is one word per cycle; back pressure on
// the result side stalls input only while a result waits. After shutdown every further
// word is answered with shutdown and off_pending set and the block state frozen.
// The user writes configuration on cfg only while idle; the block itself does not check.
module lamp_touch_key_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  // poll word: touch_level[0], key_level[1], low_power[2], now_ms[34:3], zero pad
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ltkc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // result word: luminance_write[0], luminance[8:1], colour_step[9],
  // dot_mode_toggle[10], off_pending[11], shutdown[12], zero pad
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ltkc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ltkc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ltkc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic [7:0]  level_zero, level_one, level_two, level_three;
  logic [15:0] long_press_ms, idle_off_ticks, low_power_off_ticks, off_grace_ticks;

  // Tick state
  logic        started, touch_seen_released, key_seen_released;
  logic        previous_touch, previous_key;
  logic [31:0] touch_start_ms, key_start_ms;
  logic [3:0]  touch_hold_phase, key_hold_phase;
  logic        ramp_up;
  logic [7:0]  current_level;
  logic        pending_off;
  logic [16:0] idle_count;
  logic        low_power_latched, halted;

  logic        started_next, touch_seen_released_next, key_seen_released_next;
  logic        previous_touch_next, previous_key_next;
  logic [31:0] touch_start_ms_next, key_start_ms_next;
  logic [3:0]  touch_hold_phase_next, key_hold_phase_next;
  logic        ramp_up_next;
  logic [7:0]  current_level_next;
  logic        pending_off_next;
  logic [16:0] idle_count_next;
  logic        low_power_latched_next, halted_next;

  // Result register
  logic              out_valid;
  ltkc_pkg::result_t out_word;
  ltkc_pkg::result_t out_word_next;

  logic        in_accept;
  logic        touch, key, lowp;
  logic [31:0] now_ms;

  assign touch  = s_axis_tdata[0];
  assign key    = s_axis_tdata[1];
  assign lowp   = s_axis_tdata[2];
  assign now_ms = s_axis_tdata[34:3];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;
  assign cfg_ready     = 1'b1;

  // Work out the next state and the result for the word at the input
  always_comb begin
    logic        wr, col, dot, sd;
    logic [31:0] touch_elapsed, key_elapsed;
    logic [4:0]  touch_phase_inc, key_phase_inc;
    logic [15:0] limit;
    logic [16:0] idle_inc, shutdown_limit;

    started_next             = started;
    touch_seen_released_next = touch_seen_released;
    key_seen_released_next   = key_seen_released;
    previous_touch_next      = previous_touch;
    previous_key_next        = previous_key;
    touch_start_ms_next      = touch_start_ms;
    key_start_ms_next        = key_start_ms;
    touch_hold_phase_next    = touch_hold_phase;
    key_hold_phase_next      = key_hold_phase;
    ramp_up_next             = ramp_up;
    current_level_next       = current_level;
    pending_off_next         = pending_off;
    idle_count_next          = idle_count;
    low_power_latched_next   = low_power_latched;
    halted_next              = halted;
    wr  = 1'b0;
    col = 1'b0;
    dot = 1'b0;
    sd  = 1'b0;
    touch_elapsed   = 32'd0;
    key_elapsed     = 32'd0;
    touch_phase_inc = 5'd0;
    key_phase_inc   = 5'd0;
    limit           = 16'd0;
    idle_inc        = 17'd0;
    shutdown_limit  = 17'd0;

    if (halted) begin
      sd = 1'b1;
    end else begin
      // load level one and start times on the first tick
      if (!started) begin
        started_next        = 1'b1;
        current_level_next  = level_one;
        touch_start_ms_next = now_ms;
        key_start_ms_next   = now_ms;
      end
      if (!touch) touch_seen_released_next = 1'b1;
      if (!key) key_seen_released_next = 1'b1;

      if (touch_seen_released_next && key_seen_released_next) begin
        touch_elapsed   = now_ms - touch_start_ms_next;
        key_elapsed     = now_ms - key_start_ms_next;
        touch_phase_inc = {1'b0, touch_hold_phase} + 5'd1;
        key_phase_inc   = {1'b0, key_hold_phase} + 5'd1;

        // touch: low power override, hold ramp or short-press step
        if (lowp) begin
          current_level_next = pending_off ? 8'd0 : ltkc_pkg::LOW_POWER_LEVEL;
          wr = 1'b1;
        end else if (touch) begin
          if (!previous_touch) begin
            touch_hold_phase_next = 4'd0;
            touch_start_ms_next   = now_ms;
          end else if (touch_elapsed > {16'd0, long_press_ms}) begin
            if (touch_phase_inc >= ltkc_pkg::TOUCH_PHASES) begin
              touch_hold_phase_next = 4'd0;
              if (current_level_next == ltkc_pkg::RAMP_TOP) ramp_up_next = 1'b0;
              else if (current_level_next <= ltkc_pkg::RAMP_FLOOR) ramp_up_next = 1'b1;
              current_level_next = ramp_up_next ? current_level_next + 8'd1
                                                : current_level_next - 8'd1;
              wr = 1'b1;
            end else begin
              touch_hold_phase_next = touch_phase_inc[3:0];
            end
          end
        end else if (previous_touch) begin
          if (touch_elapsed <= {16'd0, long_press_ms}) begin
            if (current_level_next < level_one) current_level_next = level_one;
            else if (current_level_next < level_two) current_level_next = level_two;
            else if (current_level_next < level_three) current_level_next = level_three;
            else current_level_next = level_zero;
            wr = 1'b1;
          end
        end

        // key: hold pulses colour step, short press pulses dot toggle
        if (key) begin
          if (!previous_key) begin
            key_hold_phase_next = 4'd0;
            key_start_ms_next   = now_ms;
          end else if (key_elapsed > {16'd0, long_press_ms}) begin
            if (key_phase_inc >= ltkc_pkg::KEY_PHASES) begin
              key_hold_phase_next = 4'd0;
              col = 1'b1;
            end else begin
              key_hold_phase_next = key_phase_inc[3:0];
            end
          end
        end else if (previous_key) begin
          if (key_elapsed <= {16'd0, long_press_ms}) dot = 1'b1;
        end

        previous_touch_next = touch;
        previous_key_next   = key;

        // count idle or low-power ticks toward shutdown
        if (lowp || current_level_next == level_zero) begin
          if (lowp) low_power_latched_next = 1'b1;
          limit    = low_power_latched_next ? low_power_off_ticks : idle_off_ticks;
          idle_inc = (idle_count < ltkc_pkg::COUNT_MAX) ? idle_count + 17'd1 : idle_count;
          idle_count_next = idle_inc;
          shutdown_limit  = {1'b0, limit} + {1'b0, off_grace_ticks};
          if (idle_inc >= {1'b0, limit}) begin
            pending_off_next = 1'b1;
            if (idle_inc >= shutdown_limit) begin
              halted_next = 1'b1;
              sd = 1'b1;
            end
          end
        end else begin
          idle_count_next = 17'd0;
        end
      end
    end

    out_word_next.pad             = 3'd0;
    out_word_next.shutdown        = sd;
    out_word_next.off_pending     = pending_off_next;
    out_word_next.dot_mode_toggle = dot;
    out_word_next.colour_step     = col;
    out_word_next.luminance       = current_level_next;
    out_word_next.luminance_write = wr;
  end

  // Hold configuration; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      level_zero          <= ltkc_pkg::LEVEL_ZERO_RST;
      level_one           <= ltkc_pkg::LEVEL_ONE_RST;
      level_two           <= ltkc_pkg::LEVEL_TWO_RST;
      level_three         <= ltkc_pkg::LEVEL_THREE_RST;
      long_press_ms       <= ltkc_pkg::LONG_PRESS_MS_RST;
      idle_off_ticks      <= ltkc_pkg::IDLE_OFF_TICKS_RST;
      low_power_off_ticks <= ltkc_pkg::LOW_POWER_OFF_TICKS_RST;
      off_grace_ticks     <= ltkc_pkg::OFF_GRACE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ltkc_pkg::REG_LEVEL_ZERO:          level_zero          <= cfg_data[7:0];
        ltkc_pkg::REG_LEVEL_ONE:           level_one           <= cfg_data[7:0];
        ltkc_pkg::REG_LEVEL_TWO:           level_two           <= cfg_data[7:0];
        ltkc_pkg::REG_LEVEL_THREE:         level_three         <= cfg_data[7:0];
        ltkc_pkg::REG_LONG_PRESS_MS:       long_press_ms       <= cfg_data;
        ltkc_pkg::REG_IDLE_OFF_TICKS:      idle_off_ticks      <= cfg_data;
        ltkc_pkg::REG_LOW_POWER_OFF_TICKS: low_power_off_ticks <= cfg_data;
        ltkc_pkg::REG_OFF_GRACE_TICKS:     off_grace_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the tick state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      started             <= 1'b0;
      touch_seen_released <= 1'b0;
      key_seen_released   <= 1'b0;
      previous_touch      <= 1'b0;
      previous_key        <= 1'b0;
      touch_start_ms      <= 32'd0;
      key_start_ms        <= 32'd0;
      touch_hold_phase    <= 4'd0;
      key_hold_phase      <= 4'd0;
      ramp_up             <= 1'b1;
      current_level       <= 8'd0;
      pending_off         <= 1'b0;
      idle_count          <= 17'd0;
      low_power_latched   <= 1'b0;
      halted              <= 1'b0;
    end else if (in_accept) begin
      started             <= started_next;
      touch_seen_released <= touch_seen_released_next;
      key_seen_released   <= key_seen_released_next;
      previous_touch      <= previous_touch_next;
      previous_key        <= previous_key_next;
      touch_start_ms      <= touch_start_ms_next;
      key_start_ms        <= key_start_ms_next;
      touch_hold_phase    <= touch_hold_phase_next;
      key_hold_phase      <= key_hold_phase_next;
      ramp_up             <= ramp_up_next;
      current_level       <= current_level_next;
      pending_off         <= pending_off_next;
      idle_count          <= idle_count_next;
      low_power_latched   <= low_power_latched_next;
      halted              <= halted_next;
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_word <= out_word_next;
    end
  end

endmodule

// File: src/ltkc_checker.sv
// Port-level checks for the lamp touch/key controller and their bind.
module ltkc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ltkc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic shutdown_seen;
  logic out_take;

  assign out_take = m_axis_tvalid && m_axis_tready;

  // Track a delivered shutdown word
  always_ff @(posedge clk) begin
    if (rst) begin
      shutdown_seen <= 1'b0;
    end else if (out_take && m_axis_tdata[12]) begin
      shutdown_seen <= 1'b1;
    end
  end

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // Shutdown is only reported with off_pending set
  a_shutdown_pending: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[11])
    else $error("shutdown without off_pending");

  // Colour step and dot toggle come from opposite key levels
  a_pulse_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[10]))
    else $error("colour step and dot toggle in one word");

  // After shutdown every word is a frozen halt word
  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && shutdown_seen |->
      m_axis_tdata[12] && m_axis_tdata[11] && !m_axis_tdata[0] &&
      !m_axis_tdata[9] && !m_axis_tdata[10])
    else $error("activity after shutdown");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

endmodule

bind lamp_touch_key_controller_top ltkc_checker u_ltkc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_lamp_touch_key_controller_top.sv
// Self-checking stream testbench for the lamp touch/key controller top level.
module tb_lamp_touch_key_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 175;
  localparam int MAX_PRINTED    = 50;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // poll word: touch_level, key_level, low_power, now_ms, zero pad
  logic [ltkc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // result word: luminance_write, luminance, colour_step, dot_mode_toggle,
  // off_pending, shutdown, zero pad
  logic [ltkc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ltkc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ltkc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int error_count        = 0;
  int words_sent         = 0;
  int results_checked    = 0;
  int settings_applied   = 0;
  int stall_cycles       = 0;
  logic [31:0] poll_clock_ms = '0;

  // Predicted results, oldest first
  ltkc_pkg::result_t lamp_expected[$];
  ltkc_pkg::result_t seen_result;
  ltkc_pkg::result_t due_result;

  // Register copy
  logic [7:0]  step_level [4] = '{ltkc_pkg::LEVEL_ZERO_RST, ltkc_pkg::LEVEL_ONE_RST,
                                  ltkc_pkg::LEVEL_TWO_RST, ltkc_pkg::LEVEL_THREE_RST};
  logic [15:0] long_press      = ltkc_pkg::LONG_PRESS_MS_RST;
  logic [15:0] idle_limit      = ltkc_pkg::IDLE_OFF_TICKS_RST;
  logic [15:0] low_power_limit = ltkc_pkg::LOW_POWER_OFF_TICKS_RST;
  logic [15:0] grace_ticks     = ltkc_pkg::OFF_GRACE_TICKS_RST;

  // Lamp state copy
  bit          lamp_started, touch_released, key_released, touch_was, key_was;
  logic [31:0] touch_t0 = '0;
  logic [31:0] key_t0 = '0;
  logic [3:0]  touch_phase = '0;
  logic [3:0]  key_phase = '0;
  bit          ramp_up = 1'b1;
  logic [7:0]  lamp_level = '0;
  bit          off_pending_q, low_power_seen, lamp_halted;
  logic [16:0] idle_count = '0;

  lamp_touch_key_controller_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute one tick of the lamp and advance the state copy
  task automatic lamp_tick(input bit touch, input bit key, input bit lowp,
                           input logic [31:0] now, output ltkc_pkg::result_t res);
    bit          wr, col, dot, sd;
    logic [31:0] held;
    logic [15:0] limit;
    wr = 1'b0;
    col = 1'b0;
    dot = 1'b0;
    sd = 1'b0;
    if (lamp_halted) begin
      sd = 1'b1;
    end else begin
      if (!lamp_started) begin
        lamp_started = 1'b1;
        lamp_level = step_level[1];
        touch_t0 = now;
        key_t0 = now;
      end
      if (!touch) touch_released = 1'b1;
      if (!key) key_released = 1'b1;
      if (touch_released && key_released) begin
        // touch: forced level in low power, ramp on hold, step on short press
        if (lowp) begin
          lamp_level = off_pending_q ? 8'd0 : ltkc_pkg::LOW_POWER_LEVEL;
          wr = 1'b1;
        end else if (touch) begin
          held = now - touch_t0;
          if (!touch_was) begin
            touch_phase = '0;
            touch_t0 = now;
          end else if (held > 32'(long_press)) begin
            touch_phase++;
            if (touch_phase >= ltkc_pkg::TOUCH_PHASES) begin
              touch_phase = '0;
              if (lamp_level == ltkc_pkg::RAMP_TOP) ramp_up = 1'b0;
              else if (lamp_level <= ltkc_pkg::RAMP_FLOOR) ramp_up = 1'b1;
              lamp_level = ramp_up ? lamp_level + 8'd1 : lamp_level - 8'd1;
              wr = 1'b1;
            end
          end
        end else if (touch_was) begin
          held = now - touch_t0;
          if (held <= 32'(long_press)) begin
            if (lamp_level < step_level[1]) lamp_level = step_level[1];
            else if (lamp_level < step_level[2]) lamp_level = step_level[2];
            else if (lamp_level < step_level[3]) lamp_level = step_level[3];
            else lamp_level = step_level[0];
            wr = 1'b1;
          end
        end
        // key: colour pulse on hold, dot toggle on short press
        held = now - key_t0;
        if (key) begin
          if (!key_was) begin
            key_phase = '0;
            key_t0 = now;
          end else if (held > 32'(long_press)) begin
            key_phase++;
            if (key_phase >= ltkc_pkg::KEY_PHASES) begin
              key_phase = '0;
              col = 1'b1;
            end
          end
        end else if (key_was) begin
          if (held <= 32'(long_press)) dot = 1'b1;
        end
        touch_was = touch;
        key_was = key;
        // shutdown timer
        if (lowp || lamp_level == step_level[0]) begin
          if (lowp) low_power_seen = 1'b1;
          limit = low_power_seen ? low_power_limit : idle_limit;
          if (idle_count < ltkc_pkg::COUNT_MAX) idle_count++;
          if (idle_count >= {1'b0, limit}) begin
            off_pending_q = 1'b1;
            if (int'(idle_count) >= int'(limit) + int'(grace_ticks)) begin
              lamp_halted = 1'b1;
              sd = 1'b1;
            end
          end
        end else begin
          idle_count = '0;
        end
      end
    end
    res = '0;
    res.luminance_write = wr;
    res.luminance       = lamp_level;
    res.colour_step     = col;
    res.dot_mode_toggle = dot;
    res.off_pending     = off_pending_q;
    res.shutdown        = sd;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("[%0t] mismatch on %s at result %0d: got %0d, want %0d",
               $time, what, results_checked, got, want);
  endtask

  // Advance the poll clock and send one poll word, then predict its result
  task automatic poll(input bit touch, input bit key, input bit lowp, input logic [31:0] dt);
    ltkc_pkg::result_t due;
    poll_clock_ms += dt;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, poll_clock_ms, lowp, key, touch};
    do @(posedge clk); while (!s_axis_tready);
    lamp_tick(touch, key, lowp, poll_clock_ms, due);
    lamp_expected.push_back(due);
    words_sent++;
  endtask

  // Hold the sender until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (lamp_expected.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input logic [ltkc_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [ltkc_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ltkc_pkg::REG_LEVEL_ZERO:          step_level[0] = value[7:0];
      ltkc_pkg::REG_LEVEL_ONE:           step_level[1] = value[7:0];
      ltkc_pkg::REG_LEVEL_TWO:           step_level[2] = value[7:0];
      ltkc_pkg::REG_LEVEL_THREE:         step_level[3] = value[7:0];
      ltkc_pkg::REG_LONG_PRESS_MS:       long_press = value;
      ltkc_pkg::REG_IDLE_OFF_TICKS:      idle_limit = value;
      ltkc_pkg::REG_LOW_POWER_OFF_TICKS: low_power_limit = value;
      ltkc_pkg::REG_OFF_GRACE_TICKS:     grace_ticks = value;
      default: ;
    endcase
  endtask

  // Rewrite every register once the block is idle; level words carry junk upper bits
  task automatic set_config(input logic [7:0] l0, input logic [7:0] l1,
                            input logic [7:0] l2, input logic [7:0] l3,
                            input logic [15:0] press_ms, input logic [15:0] idle_t,
                            input logic [15:0] lowp_t, input logic [15:0] grace_t,
                            input bit with_unused);
    drain_results();
    write_register(ltkc_pkg::REG_LEVEL_ZERO, {8'($urandom), l0});
    write_register(ltkc_pkg::REG_LEVEL_ONE, {8'($urandom), l1});
    write_register(ltkc_pkg::REG_LEVEL_TWO, {8'($urandom), l2});
    write_register(ltkc_pkg::REG_LEVEL_THREE, {8'($urandom), l3});
    write_register(ltkc_pkg::REG_LONG_PRESS_MS, press_ms);
    write_register(ltkc_pkg::REG_IDLE_OFF_TICKS, idle_t);
    write_register(ltkc_pkg::REG_LOW_POWER_OFF_TICKS, lowp_t);
    write_register(ltkc_pkg::REG_OFF_GRACE_TICKS, grace_t);
    if (with_unused)
      for (int i = int'(ltkc_pkg::REG_OFF_GRACE_TICKS) + 1;
           i < (1 << ltkc_pkg::CFG_INDEX_W); i++)
        write_register(i[ltkc_pkg::CFG_INDEX_W-1:0], 16'($urandom));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Mostly well-formed press sequences with random timing, plus low power and noise
  task automatic random_burst(input int n_items);
    int          first, kind;
    logic [31:0] span, window;
    first = words_sent;
    while (words_sent - first < n_items) begin
      kind = $urandom_range(99);
      window = 32'(long_press);
      case ($urandom_range(3))
        0:       span = window;
        1:       span = window + 1;
        default: span = $urandom_range(0, window);
      endcase
      if (kind < 25) begin
        poll(1'b1, 1'b0, 1'b0, $urandom_range(1, 20));
        if ($urandom_range(1)) begin
          poll(1'b1, 1'b0, 1'b0, span / 2);
          poll(1'b0, 1'b0, 1'b0, span - span / 2);
        end else begin
          poll(1'b0, 1'b0, 1'b0, span);
        end
      end else if (kind < 45) begin
        poll(1'b1, 1'b0, 1'b0, $urandom_range(1, 20));
        poll(1'b1, 1'b0, 1'b0, window + 1 + $urandom_range(0, 30));
        repeat ($urandom_range(14, 60)) poll(1'b1, 1'b0, 1'b0, $urandom_range(0, 3));
        poll(1'b0, 1'b0, 1'b0, $urandom_range(1, 50));
      end else if (kind < 60) begin
        poll(1'b0, 1'b1, 1'b0, $urandom_range(1, 20));
        poll(1'b0, 1'b0, 1'b0, span);
      end else if (kind < 72) begin
        poll(1'b0, 1'b1, 1'b0, $urandom_range(1, 20));
        poll(1'b0, 1'b1, 1'b0, window + 1 + $urandom_range(0, 30));
        repeat ($urandom_range(9, 35)) poll(1'b0, 1'b1, 1'b0, $urandom_range(0, 3));
        poll(1'b0, 1'b0, 1'b0, $urandom_range(1, 50));
      end else if (kind < 80) begin
        poll(1'b1, 1'b1, 1'b0, $urandom_range(1, 20));
        poll(1'b1, 1'b1, 1'b0, window + 1 + $urandom_range(0, 30));
        repeat ($urandom_range(15, 40)) poll(1'b1, 1'b1, 1'b0, $urandom_range(0, 3));
        poll(1'b0, 1'b0, 1'b0, $urandom_range(1, 50));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 4))
          poll(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1, $urandom_range(0, 50));
      end else begin
        repeat ($urandom_range(1, 3))
          poll(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
               $urandom);
      end
    end
  endtask

  // First tick loads level one; nothing acts until touch and key are seen released
  task automatic test_power_up();
    poll_clock_ms = 32'hFFFF_FFF0;
    poll(1'b1, 1'b1, 1'b0, 32'd0);
    poll(1'b0, 1'b1, 1'b0, 32'd3);
    poll(1'b0, 1'b0, 1'b0, 32'd3);
  endtask

  // Step through all levels across the time wrap, then the long-press boundary
  task automatic test_short_touch();
    repeat (4) begin
      poll(1'b1, 1'b0, 1'b0, 32'd2);
      poll(1'b0, 1'b0, 1'b0, 32'd5);
    end
    poll(1'b1, 1'b0, 1'b0, 32'd2);
    poll(1'b0, 1'b0, 1'b0, 32'(long_press));
    poll(1'b1, 1'b0, 1'b0, 32'd2);
    poll(1'b0, 1'b0, 1'b0, 32'(long_press) + 32'd1);
  endtask

  task automatic test_key_press();
    poll(1'b0, 1'b1, 1'b0, 32'd2);
    poll(1'b0, 1'b0, 1'b0, 32'd7);
    poll(1'b0, 1'b1, 1'b0, 32'd2);
    poll(1'b0, 1'b0, 1'b0, 32'(long_press) + 32'd1);
  endtask

  // Low power forces the fixed level and latches the low-power limit
  task automatic test_low_power();
    poll(1'b0, 1'b0, 1'b1, 32'd1);
    poll(1'b1, 1'b1, 1'b1, 32'd1);
    poll(1'b0, 1'b0, 1'b0, 32'd1);
    poll(1'b0, 1'b0, 1'b1, 32'd1);
  endtask

  task automatic test_free_flow();
    set_config(8'd20, 8'd100, 8'd180, 8'd255, 16'd40, 16'd65535, 16'd65535, 16'd65535, 1'b1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    random_burst(PHASE_ITEMS);
  endtask

  // Unordered levels and a 1 ms long-press window; pause once mid-phase
  task automatic test_sender_gaps();
    set_config(8'd30, 8'd200, 8'd50, 8'd100, 16'd1, 16'd1, 16'd65535, 16'd65535, 1'b0);
    sender_idle_pct = 56;
    receiver_stall_pct = 0;
    random_burst(PHASE_ITEMS / 2);
    drain_results();
    random_burst(PHASE_ITEMS / 2);
  endtask

  task automatic test_receiver_stalls();
    set_config(8'd255, 8'd0, 8'd128, 8'd254, 16'd65535, 16'd32768, 16'd65535, 16'd0, 1'b0);
    sender_idle_pct = 0;
    receiver_stall_pct = 56;
    random_burst(PHASE_ITEMS);
  endtask

  task automatic test_mixed_backpressure();
    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               16'($urandom_range(1, 200)), 16'd60000, 16'd65535,
               16'($urandom_range(1000, 65535)), 1'b1);
    sender_idle_pct = 26;
    receiver_stall_pct = 26;
    random_burst(PHASE_ITEMS);
  endtask

  // Reach off-pending at once, shut down after the grace ticks, then poll the halted block
  task automatic test_timed_shutdown();
    int tick_no;
    set_config(8'd0, 8'd64, 8'd128, 8'd255, 16'd1000, 16'd65535, 16'd1, 16'd40, 1'b0);
    tick_no = 0;
    while (!lamp_halted) begin
      poll(1'($urandom_range(1)), 1'($urandom_range(1)),
           (tick_no >= 10) || ($urandom_range(1) != 0), $urandom_range(0, 100));
      tick_no++;
    end
    repeat (8)
      poll(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
  endtask

  // Sink side: stall at the rate of the current phase
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

  // Compare each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_result = ltkc_pkg::result_t'(m_axis_tdata);
      if (lamp_expected.size() == 0) begin
        report_mismatch("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        due_result = lamp_expected.pop_front();
        if (seen_result.luminance_write !== due_result.luminance_write)
          report_mismatch("luminance_write", int'(seen_result.luminance_write),
                          int'(due_result.luminance_write));
        if (seen_result.luminance !== due_result.luminance)
          report_mismatch("luminance", int'(seen_result.luminance),
                          int'(due_result.luminance));
        if (seen_result.colour_step !== due_result.colour_step)
          report_mismatch("colour_step", int'(seen_result.colour_step),
                          int'(due_result.colour_step));
        if (seen_result.dot_mode_toggle !== due_result.dot_mode_toggle)
          report_mismatch("dot_mode_toggle", int'(seen_result.dot_mode_toggle),
                          int'(due_result.dot_mode_toggle));
        if (seen_result.off_pending !== due_result.off_pending)
          report_mismatch("off_pending", int'(seen_result.off_pending),
                          int'(due_result.off_pending));
        if (seen_result.shutdown !== due_result.shutdown)
          report_mismatch("shutdown", int'(seen_result.shutdown),
                          int'(due_result.shutdown));
        if (seen_result.pad !== due_result.pad)
          report_mismatch("pad bits", int'(seen_result.pad), int'(due_result.pad));
        results_checked++;
      end
    end
  end

  // Drop the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               stall_cycles, lamp_expected.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_power_up();
    test_short_touch();
    test_key_press();
    test_low_power();
    test_free_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_backpressure();
    test_timed_shutdown();
    drain_results();
    if (lamp_expected.size() != 0)
      report_mismatch("results left over", lamp_expected.size(), 0);
    $display("Summary: %0d poll words sent, %0d result words checked, %0d register settings",
             words_sent, results_checked, settings_applied);
    $display("Summary: level steps, ramps, key pulses, low power and timed shutdown under stalls");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ltkc_pkg.sv
src/lamp_touch_key_controller_top.sv
src/ltkc_checker.sv
tb/tb_lamp_touch_key_controller_top.sv
